### design/base64_decoder_top_macros.svh
// Assertion macros shared by the base64 decoder RTL.
// Used by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef BASE64_DECODER_TOP_MACROS_SVH
`define BASE64_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define B64D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64d check failed");

// Next-cycle implication, disabled while reset is asserted
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64d check failed");

`endif

### design/b64d_pkg.sv
// Package for the base64 decoder: result kinds, queue entry type, constants.
// No dependencies; imported by every module of the block.
package b64d_pkg;

    // Result kinds, carried on tuser
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    localparam logic [7:0]  PAD_CHAR  = 8'h3D;   // '='
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One request for the back end: up to three data bytes then an optional tail
    typedef struct packed {
        logic [1:0]  n_data;     // data bytes in this request, 0..3
        logic        has_tail;   // a finished or error result follows the bytes
        t_kind       tail_kind;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [23:0] count;      // total byte count for a finished result
    } t_entry;

    // Sextet lookup: bit 6 set when the character is in the alphabet
    function automatic logic [6:0] f_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

### design/b64d_front.sv
// Front end: accepts characters, keeps the group state and builds back-end requests.
// Depends on b64d_pkg.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_end,
    input  logic       i_room,      // queue can take a request
    output logic       o_ready,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [1:0]  r_pos,   n_pos;
    logic [17:0] r_held,  n_held;
    logic        r_third, n_third;
    logic        r_skip,  n_skip;
    logic [23:0] r_bytes, n_bytes;

    logic [6:0]  sx;
    logic        ok, pad, bad, accept;
    logic [5:0]  s_in;
    logic [24:0] sum;
    logic [1:0]  nd;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;
    assign sx      = f_sextet(i_char);
    assign ok      = sx[6];
    assign pad     = (i_char == PAD_CHAR);
    assign bad     = !ok && !(pad && r_pos[1]);
    assign s_in    = ok ? sx[5:0] : 6'd0;
    assign nd      = r_third ? 2'd1 : (pad ? 2'd2 : 2'd3);
    assign sum     = {1'b0, r_bytes} + 25'(nd);

    // Classification and next state
    always_comb begin
        n_pos   = r_pos;
        n_held  = r_held;
        n_third = r_third;
        n_skip  = r_skip;
        n_bytes = r_bytes;
        o_push  = 1'b0;
        o_entry = '0;
        o_entry.tail_kind = KIND_ERROR;
        if (accept) begin
            if (r_skip) begin
                if (i_end) begin
                    n_pos = 2'd0; n_held = '0; n_third = 1'b0; n_skip = 1'b0; n_bytes = '0;
                end
            end else if (bad) begin
                o_push = 1'b1;
                o_entry.has_tail = 1'b1;
                if (i_end) begin
                    n_pos = 2'd0; n_held = '0; n_third = 1'b0; n_skip = 1'b0; n_bytes = '0;
                end else begin
                    n_skip = 1'b1;
                end
            end else if (r_pos != 2'd3) begin
                n_held = {r_held[11:0], s_in};
                if (r_pos == 2'd2) begin
                    n_third = pad;
                end
                n_pos = r_pos + 2'd1;
                if (i_end) begin
                    o_push = 1'b1;
                    o_entry.has_tail = 1'b1;
                    n_pos = 2'd0; n_held = '0; n_third = 1'b0; n_skip = 1'b0; n_bytes = '0;
                end
            end else begin
                // fourth character: emit the group
                o_push = 1'b1;
                o_entry.n_data = nd;
                o_entry.byte1  = {r_held[17:12], r_held[11:10]};
                o_entry.byte2  = {r_held[9:6], r_held[5:2]};
                o_entry.byte3  = {r_held[1:0], s_in};
                n_bytes = sum[24] ? COUNT_MAX : sum[23:0];
                o_entry.count     = n_bytes;
                o_entry.has_tail  = pad || i_end;
                o_entry.tail_kind = KIND_DONE;
                n_pos   = 2'd0;
                n_held  = '0;
                n_third = 1'b0;
                if (i_end) begin
                    n_skip = 1'b0; n_bytes = '0;
                end else if (pad) begin
                    n_skip = 1'b1;
                end
            end
        end
    end

    // Group state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_held  <= '0;
            r_third <= 1'b0;
            r_skip  <= 1'b0;
            r_bytes <= '0;
        end else begin
            r_pos   <= n_pos;
            r_held  <= n_held;
            r_third <= n_third;
            r_skip  <= n_skip;
            r_bytes <= n_bytes;
        end
    end

endmodule

### design/b64d_queue.sv
// Short request queue between front and back ends, held in flip-flops.
// Depends on b64d_pkg and base64_decoder_top_macros.svh.
`include "base64_decoder_top_macros.svh"
module b64d_queue
    import b64d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_room,
    output logic   o_avail,
    output t_entry o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_CW-1:0] r_count;

    assign o_room  = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `B64D_ASSERT_NOW(a_no_push_full, !o_room, !i_push)
    `B64D_ASSERT_NOW(a_no_pop_empty, !o_avail, !i_pop)
    `B64D_ASSERT_NEXT(a_fill_up, i_push && !i_pop, r_count == QUEUE_CW'($past(r_count) + 1'b1))

endmodule

### design/b64d_back.sv
// Back end: expands each request into results, one per cycle unless stalled, into the output register.
// Depends on b64d_pkg.
module b64d_back
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_kind       o_kind,
    output logic [7:0]  o_byte,
    output logic [23:0] o_count,
    output logic        o_last
);

    logic [1:0]  r_idx, n_idx;
    logic        r_valid;
    t_kind       r_kind;
    logic [7:0]  r_byte;
    logic [23:0] r_count;
    logic        r_last;

    logic        load, is_data, last_res;
    logic [2:0]  total;
    logic [7:0]  sel_byte;

    assign total    = {1'b0, i_head.n_data} + {2'b00, i_head.has_tail};
    assign load     = i_avail && (!r_valid || i_ready);
    assign is_data  = (r_idx < i_head.n_data);
    assign last_res = (({1'b0, r_idx} + 3'd1) == total);
    assign o_pop    = load && last_res;

    // Byte of the group at the current index
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.byte1;
            2'd1:    sel_byte = i_head.byte2;
            default: sel_byte = i_head.byte3;
        endcase
    end

    // Result index within the head request
    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = last_res ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= is_data ? KIND_DATA : i_head.tail_kind;
            r_byte  <= is_data ? sel_byte : 8'd0;
            r_count <= (!is_data && i_head.tail_kind == KIND_DONE) ? i_head.count : 24'd0;
            r_last  <= last_res;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_count = r_count;
    assign o_last  = r_last;

endmodule

### design/base64_decoder_top.sv
// Top level of the streaming base64 decoder: front end, request queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//  channel     direction  fields (low bit up)
//  s_axis      in         tdata: char_code[7:0]; tlast: end_of_text
//  m_axis      out        tdata: data_byte[7:0], byte_count[31:8]; tuser: kind; tlast: last_of_run
//
// One character is accepted per cycle while the four-entry request queue has room.
// The back end delivers one result per cycle while m_axis is not stalled, and a group
// yields up to four results; each request passes the queue and then the output register.
// Reset is synchronous and clears the group state, queue pointers and output valid at once.
// A stall on m_axis fills the queue; s_axis tready falls only when it is full.
module base64_decoder_top
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // char_code[7:0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,    // data_byte[7:0], byte_count[31:8]
    output logic [1:0]  o_m_axis_tuser,    // kind[1:0]
    output logic        o_m_axis_tlast
);

    logic        room, avail, push, pop;
    t_entry      entry, head;
    t_kind       kind;
    logic [7:0]  data_byte;
    logic [23:0] byte_count;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_char  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .i_room  (room),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_entry (entry)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_room  (room),
        .o_avail (avail),
        .o_head  (head)
    );

    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (kind),
        .o_byte  (data_byte),
        .o_count (byte_count),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {byte_count, data_byte};
    assign o_m_axis_tuser = kind;

endmodule

### tb/sv/base64_decoder_top_tb.sv
// Self-checking testbench for base64_decoder_top: directed and random character streams,
// checked against an in-bench decoder model with random stalls on both streams.
// Depends on b64d_pkg and the base64_decoder_top RTL.
`timescale 1ns / 1ps

module base64_decoder_top_tb;
    import b64d_pkg::*;

    localparam int RANDOM_ITEMS   = 410;
    localparam int HOLD_CYCLES    = 80;    // long receiver hold-off, fills the request queue
    localparam int WATCHDOG_LIMIT = 1000;  // covers the longest gap, the hold-off and 4 results per item
    localparam int DRAIN_CYCLES   = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;    // char_code[7:0]
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;    // data_byte[7:0], byte_count[31:8]
    logic [1:0]  o_m_axis_tuser;    // kind[1:0]
    logic        o_m_axis_tlast;

    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        logic [23:0] count;
        logic        last;
    } t_decode_result;

    // Sextet of a base64 character, -1 when outside the alphabet
    function automatic int sextet_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
        if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
        if (c == 8'h2B) return 62;
        if (c == 8'h2F) return 63;
        return -1;
    endfunction

    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26) return 8'(8'h41 + idx);
        if (idx < 52) return 8'(8'h61 + idx - 26);
        if (idx < 62) return 8'(8'h30 + idx - 52);
        if (idx == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    // Decoder model plus the store of results still owed by the block
    class decode_scoreboard;
        logic [1:0]     group_pos;
        logic [17:0]    sextets;
        bit             third_pad;
        bit             skipping;
        logic [23:0]    total_bytes;
        t_decode_result owed_results[$];
        int             n_chars;
        int             n_results;
        int             n_bytes;
        int             n_done;
        int             n_errors;
        int             mismatches;

        function new();
            clear_string();
            n_chars    = 0;
            n_results  = 0;
            n_bytes    = 0;
            n_done     = 0;
            n_errors   = 0;
            mismatches = 0;
        endfunction

        function void clear_string();
            group_pos   = '0;
            sextets     = '0;
            third_pad   = 0;
            skipping    = 0;
            total_bytes = '0;
        endfunction

        function void push_result(ref t_decode_result step_q[$], input t_kind kind,
                                  input logic [7:0] data, input logic [23:0] count);
            t_decode_result r;
            r.kind  = kind;
            r.data  = data;
            r.count = count;
            r.last  = 1'b0;
            step_q.push_back(r);
        endfunction

        function void push_byte(ref t_decode_result step_q[$], input logic [7:0] data);
            push_result(step_q, KIND_DATA, data, '0);
            if (total_bytes != COUNT_MAX) total_bytes++;
        endfunction

        // One accepted character: work out the results it causes
        function void note_char(input logic [7:0] c, input logic eot);
            t_decode_result step_q[$];
            bit             pad;
            int             sx;
            logic [5:0]     s1, s2, s3, s4;
            n_chars++;
            pad = (c == PAD_CHAR);
            sx  = sextet_value(c);
            if (skipping) begin
                if (eot) clear_string();
                return;
            end
            if (sx < 0 && !(pad && group_pos >= 2)) begin
                // bad character, or pad too early in the group
                push_result(step_q, KIND_ERROR, '0, '0);
                if (eot) clear_string();
                else skipping = 1;
            end else if (group_pos < 3) begin
                s4 = pad ? 6'd0 : 6'(sx);
                sextets = {sextets[11:0], s4};
                if (group_pos == 2) third_pad = pad;
                group_pos++;
                if (eot) begin
                    // string ends inside a group
                    push_result(step_q, KIND_ERROR, '0, '0);
                    clear_string();
                end
            end else begin
                s1 = sextets[17:12];
                s2 = sextets[11:6];
                s3 = sextets[5:0];
                s4 = pad ? 6'd0 : 6'(sx);
                push_byte(step_q, {s1, s2[5:4]});
                if (!third_pad) begin
                    push_byte(step_q, {s2[3:0], s3[5:2]});
                    if (!pad) push_byte(step_q, {s3[1:0], s4});
                end
                group_pos = '0;
                sextets   = '0;
                third_pad = 0;
                if (pad || eot) begin
                    push_result(step_q, KIND_DONE, '0, total_bytes);
                    if (eot) clear_string();
                    else skipping = 1;
                end
            end
            if (step_q.size() > 0) begin
                step_q[step_q.size() - 1].last = 1'b1;
                foreach (step_q[i]) owed_results.push_back(step_q[i]);
            end
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] MISMATCH at result %0d: %s", $time, n_results, what);
            mismatches++;
        endtask

        // One accepted result against the oldest one owed
        task check_result(input logic [1:0] kind, input logic [7:0] data,
                          input logic [23:0] count, input logic last);
            t_decode_result want;
            n_results++;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d data=%02h count=%0d",
                                          kind, data, count));
                return;
            end
            want = owed_results.pop_front();
            case (want.kind)
                KIND_DATA:  n_bytes++;
                KIND_DONE:  n_done++;
                default:    n_errors++;
            endcase
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (data !== want.data)
                report_mismatch($sformatf("data %02h, expected %02h", data, want.data));
            if (count !== want.count)
                report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
            if (last !== want.last)
                report_mismatch($sformatf("last %b, expected %b", last, want.last));
        endtask

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    decode_scoreboard sb;
    logic [7:0]       text_q[$];
    int               tx_burst;
    int               rx_burst;
    bit               held_off;
    int               idle_cycles;

    base64_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Idle length: mostly none or short, a few long, with gap-free bursts
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst = $urandom_range(20, 40);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one character and hold it until the block takes the request
    task send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_char(c, eot);
    endtask

    task send_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++)
            send_char(8'(s[i]), end_last && (i == s.len() - 1));
    endtask

    task flush_text();
        foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (sextet_value(c) >= 0 || c == PAD_CHAR);
        return c;
    endfunction

    // Valid string: whole groups, optional padding, sometimes a mid-string third pad
    task build_well_formed();
        int ngroups;
        int tail;
        ngroups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (int g = 0; g < ngroups; g++) begin
            for (int k = 0; k < 4; k++) text_q.push_back(alpha_char($urandom_range(0, 63)));
            if (g < ngroups - 1 && $urandom_range(0, 99) < 15)
                text_q[text_q.size() - 2] = PAD_CHAR;
        end
        tail = $urandom_range(0, 2);
        if (tail >= 1) text_q[text_q.size() - 1] = PAD_CHAR;
        if (tail == 2) text_q[text_q.size() - 2] = PAD_CHAR;
        // padded end without the end flag: junk follows and is skipped
        if (tail != 0 && $urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Valid string with one defect
    task build_broken();
        int idx;
        build_well_formed();
        case ($urandom_range(0, 2))
            0: begin
                idx = $urandom_range(0, text_q.size() - 1);
                text_q[idx] = bad_char();
            end
            1: begin
                idx = 4 * $urandom_range(0, (text_q.size() - 1) / 4) + $urandom_range(0, 1);
                if (idx < text_q.size()) text_q[idx] = PAD_CHAR;
            end
            default: begin
                repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
            end
        endcase
    endtask

    // Receiver: random stalls, one long hold-off once traffic is flowing
    initial begin
        int stall;
        held_off = 0;
        rx_burst = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && sb.n_chars >= 60) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held_off = 1;
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            stall = pick_gap(rx_burst);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata[7:0], o_m_axis_tdata[31:8],
                            o_m_axis_tlast);
    end

    // Watchdog on cycles with no request moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int r;
        sb              = new();
        tx_burst        = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full group, padded ends, short end, early pad, bad characters
        send_text("TWFu", 1);
        send_text("TQ==", 1);
        send_text("+/z=", 1);
        send_char(8'h00, 1'b1);
        send_text("TW", 1);
        send_char(8'h80, 1'b1);
        send_text("A=", 1);
        // third pad only, then pad at four without end, junk skipped up to the end flag
        send_text("TQ=A////AA==", 0);
        send_char(8'h7F, 1'b0);
        send_char(8'hFF, 1'b1);

        // Random: mostly valid strings, some broken, some raw noise
        while (sb.n_chars < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                build_well_formed();
            end else if (r < 85) begin
                build_broken();
            end else begin
                repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(0, 255)));
            end
            flush_text();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d characters and %0d results:", sb.n_chars, sb.n_results);
        $display("  %0d decoded bytes, %0d finished strings, %0d decode errors",
                 sb.n_bytes, sb.n_done, sb.n_errors);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_decoder_top.sv
tb/sv/base64_decoder_top_tb.sv
